// ----- rtl/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Shared types, codes and default sizes for the heap controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY = 64;

  localparam int PRIO_W  = 16;
  localparam int TAG_W   = 32;
  localparam int COUNT_W = 7;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic start_enq;
    logic start_full;
    logic start_deq;
    logic start_empty;
    logic load_last;
    logic rd_parent;
    logic rd_children;
    logic wr_cur;
    logic up_move;
    logic dn_move;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic at_root;
    logic up_gt;
    logic is_leaf;
    logic dn_swap;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Binary max-heap of priority and payload entries with enqueue and dequeue.
// ----------------------------------------------------------------------------
// Each accepted request returns exactly one result: its status, the entry it
// removed, the new top of the heap and the entry count. Requests are handled
// one at a time, and the heap memory with two read ports and one write port
// sets the pace: each heap level takes one read step and one compare step. An
// enqueue moves up from the new last position until it reaches the root or a
// parent that is not smaller; a dequeue first loads the last entry into the
// root and moves it down until it reaches a leaf or no child is larger. An
// enqueue moves at most log2(CAPACITY) levels and a dequeue at least one level
// fewer. Full and empty requests, and a dequeue of the only entry, skip the
// heap steps. A finished result waits in an output register, so the next
// request can be accepted before the result is taken; that request finishes
// only once the waiting result has been taken.
`default_nettype none

module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // priority_req [15:0], payload [47:16]
  input  wire logic [47:0]  s_axis_tdata,
  // req_type [0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // removed_priority [15:0], removed_payload [47:16], top_priority [63:48],
  // top_payload [95:64], entry_count [102:96], zero [103]
  output logic [103:0]      m_axis_tdata,
  // status [1:0], top_valid [2]
  output logic [2:0]        m_axis_tuser
);

  mhpq_pkg::ctrl_cmd_t  cmd;
  mhpq_pkg::dp_status_t stat;

  logic [1:0]                            out_status;
  logic signed [mhpq_pkg::PRIO_W-1:0]    out_rem_prio;
  logic        [mhpq_pkg::TAG_W-1:0]     out_rem_tag;
  logic                                  out_top_valid;
  logic signed [mhpq_pkg::PRIO_W-1:0]    out_top_prio;
  logic        [mhpq_pkg::TAG_W-1:0]     out_top_tag;
  logic        [mhpq_pkg::COUNT_W-1:0]   out_count;

  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .req_type (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_prio       (s_axis_tdata[15:0]),
    .in_tag        (s_axis_tdata[47:16]),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_status    (out_status),
    .out_rem_prio  (out_rem_prio),
    .out_rem_tag   (out_rem_tag),
    .out_top_valid (out_top_valid),
    .out_top_prio  (out_top_prio),
    .out_top_tag   (out_top_tag),
    .out_count     (out_count)
  );

  assign m_axis_tdata = {1'b0, out_count, out_top_tag, out_top_prio,
                         out_rem_tag, out_rem_prio};
  assign m_axis_tuser = {out_top_valid, out_status};

endmodule

`default_nettype wire

// ----- rtl/mhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue controller
// Sequences one request at a time through sift-up or sift-down steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 req_type,
  output logic                      in_ready,
  input  wire mhpq_pkg::dp_status_t stat,
  output mhpq_pkg::ctrl_cmd_t       cmd
);

  mhpq_pkg::ctrl_state_t state, state_next;
  logic                  accept;

  assign accept = in_valid && (state == mhpq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          if (req_type == mhpq_pkg::REQ_ENQ) begin
            state_next = stat.full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_RD;
          end else if (stat.empty || stat.last_one) begin
            state_next = mhpq_pkg::S_DONE;
          end else begin
            state_next = mhpq_pkg::S_DN_LAST;
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        state_next = stat.at_root ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        state_next = stat.up_gt ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_DN_LAST: begin
        state_next = mhpq_pkg::S_DN_RD;
      end
      mhpq_pkg::S_DN_RD: begin
        state_next = stat.is_leaf ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        state_next = stat.dn_swap ? mhpq_pkg::S_DN_RD : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_next = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      mhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (req_type == mhpq_pkg::REQ_ENQ) begin
            cmd.start_enq  = !stat.full;
            cmd.start_full = stat.full;
          end else begin
            cmd.start_deq   = !stat.empty;
            cmd.start_empty = stat.empty;
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        cmd.wr_cur    = stat.at_root;
        cmd.rd_parent = !stat.at_root;
      end
      mhpq_pkg::S_UP_CMP: begin
        cmd.up_move = stat.up_gt;
        cmd.wr_cur  = !stat.up_gt;
      end
      mhpq_pkg::S_DN_LAST: begin
        cmd.load_last = 1'b1;
      end
      mhpq_pkg::S_DN_RD: begin
        cmd.wr_cur      = stat.is_leaf;
        cmd.rd_children = !stat.is_leaf;
      end
      mhpq_pkg::S_DN_CMP: begin
        cmd.dn_move = stat.dn_swap;
        cmd.wr_cur  = !stat.dn_swap;
      end
      mhpq_pkg::S_DONE: begin
        cmd.publish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mhpq_dp.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue datapath
// Heap memory, working entry, position and count registers, and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_dp #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [mhpq_pkg::PRIO_W-1:0]  in_prio,
  input  wire logic        [mhpq_pkg::TAG_W-1:0]   in_tag,
  input  wire mhpq_pkg::ctrl_cmd_t                 cmd,
  output mhpq_pkg::dp_status_t                     stat,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic             [1:0]                   out_status,
  output logic signed      [mhpq_pkg::PRIO_W-1:0]  out_rem_prio,
  output logic             [mhpq_pkg::TAG_W-1:0]   out_rem_tag,
  output logic                                     out_top_valid,
  output logic signed      [mhpq_pkg::PRIO_W-1:0]  out_top_prio,
  output logic             [mhpq_pkg::TAG_W-1:0]   out_top_tag,
  output logic             [mhpq_pkg::COUNT_W-1:0] out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  mhpq_pkg::entry_t mem [0:CAPACITY-1];

  logic [CW-1:0]     count;
  logic [AW-1:0]     pos;
  mhpq_pkg::entry_t  cur;
  mhpq_pkg::entry_t  top;
  mhpq_pkg::entry_t  removed;
  mhpq_pkg::status_t res_status;
  mhpq_pkg::entry_t  rd_a;
  mhpq_pkg::entry_t  rd_b;

  logic [AW-1:0]    parent;
  logic [XW-1:0]    left_idx;
  logic [XW-1:0]    right_idx;
  logic             right_ok;
  logic             pick_left;
  logic             pick_right;
  logic signed [mhpq_pkg::PRIO_W-1:0] best_prio;
  logic [AW-1:0]    addr_a;
  logic             rd_en;
  logic             wr_en;
  mhpq_pkg::entry_t wr_data;
  mhpq_pkg::entry_t new_entry;

  assign new_entry.prio = in_prio;
  assign new_entry.tag  = in_tag;

  assign parent    = (pos - AW'(1)) >> 1;
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = {1'b0, pos, 1'b0} + XW'(2);
  assign right_ok  = right_idx < XW'(count);

  always_comb begin
    pick_left  = 1'b0;
    pick_right = 1'b0;
    best_prio  = cur.prio;
    if (rd_a.prio > cur.prio) begin
      pick_left = 1'b1;
      best_prio = rd_a.prio;
    end
    if (right_ok && (rd_b.prio > best_prio)) begin
      pick_left  = 1'b0;
      pick_right = 1'b1;
    end
  end

  always_comb begin
    stat.full     = count == CW'(CAPACITY);
    stat.empty    = count == '0;
    stat.last_one = count == CW'(1);
    stat.at_root  = pos == '0;
    stat.up_gt    = cur.prio > rd_a.prio;
    stat.is_leaf  = left_idx >= XW'(count);
    stat.dn_swap  = pick_left || pick_right;
    stat.out_free = !out_valid || out_ready;
  end

  always_comb begin
    if (cmd.start_deq) begin
      addr_a = AW'(count - CW'(1));
    end else if (cmd.rd_parent) begin
      addr_a = parent;
    end else begin
      addr_a = left_idx[AW-1:0];
    end
  end

  assign rd_en = cmd.start_deq || cmd.rd_parent || cmd.rd_children;
  assign wr_en = cmd.wr_cur || cmd.up_move || cmd.dn_move;

  always_comb begin
    if (cmd.up_move || (cmd.dn_move && pick_left)) begin
      wr_data = rd_a;
    end else if (cmd.dn_move) begin
      wr_data = rd_b;
    end else begin
      wr_data = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[right_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start_enq) begin
      count <= count + CW'(1);
    end else if (cmd.start_deq) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (pos == '0)) begin
      top <= wr_data;
    end
    if (cmd.start_enq) begin
      cur        <= new_entry;
      pos        <= AW'(count);
      removed    <= '0;
      res_status <= mhpq_pkg::STAT_DONE;
    end else if (cmd.start_full) begin
      removed    <= '0;
      res_status <= mhpq_pkg::STAT_FULL;
    end else if (cmd.start_deq) begin
      removed    <= top;
      res_status <= mhpq_pkg::STAT_DONE;
    end else if (cmd.start_empty) begin
      removed    <= '0;
      res_status <= mhpq_pkg::STAT_EMPTY;
    end else if (cmd.load_last) begin
      cur <= rd_a;
      pos <= '0;
    end else if (cmd.up_move) begin
      pos <= parent;
    end else if (cmd.dn_move) begin
      pos <= pick_left ? left_idx[AW-1:0] : right_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status    <= res_status;
      out_rem_prio  <= removed.prio;
      out_rem_tag   <= removed.tag;
      out_top_valid <= count != '0;
      out_top_prio  <= (count != '0) ? top.prio : '0;
      out_top_tag   <= (count != '0) ? top.tag : '0;
      out_count     <= mhpq_pkg::COUNT_W'(count);
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue testbench
// Drives enqueue and dequeue requests with random gaps and back-pressure. An
// in-bench copy of the heap predicts every result, and each result transfer
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = mhpq_pkg::CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1270;

  typedef struct {
    mhpq_pkg::status_t status;
    logic [15:0]  rem_prio;
    logic [31:0]  rem_tag;
    logic         top_valid;
    logic [15:0]  top_prio;
    logic [31:0]  top_tag;
    logic [6:0]   count;
  } heap_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [47:0]   s_axis_tdata = '0;
  logic [0:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;
  logic [2:0]    m_axis_tuser;

  mhpq_pkg::entry_t heap_mem [CAP];
  int unsigned   heap_fill = 0;
  heap_result_t  expected_results [$];
  int            error_count = 0;
  int            result_index = 0;
  int            sent_count = 0;
  int            cycle_count = 0;
  bit            gap_free = 1'b0;
  int            long_hold_cycles = 0;

  max_heap_priority_queue #(.CAPACITY(CAP)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    mhpq_pkg::entry_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic heap_result_t heap_update(logic rt, logic [15:0] pr, logic [31:0] pl);
    heap_result_t r;
    int unsigned pos, up, lc, rc, best;
    r.status = mhpq_pkg::STAT_DONE;
    r.rem_prio = '0;
    r.rem_tag = '0;
    if (rt == mhpq_pkg::REQ_ENQ) begin
      if (heap_fill < CAP) begin
        heap_mem[heap_fill].prio = pr;
        heap_mem[heap_fill].tag = pl;
        heap_fill++;
        pos = heap_fill - 1;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if ($signed(heap_mem[pos].prio) > $signed(heap_mem[up].prio)) begin
            swap_entries(pos, up);
            pos = up;
          end else begin
            break;
          end
        end
      end else begin
        r.status = mhpq_pkg::STAT_FULL;
      end
    end else begin
      if (heap_fill > 0) begin
        r.rem_prio = heap_mem[0].prio;
        r.rem_tag = heap_mem[0].tag;
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        pos = 0;
        while (1) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          best = pos;
          if (lc < heap_fill && $signed(heap_mem[lc].prio) > $signed(heap_mem[best].prio))
            best = lc;
          if (rc < heap_fill && $signed(heap_mem[rc].prio) > $signed(heap_mem[best].prio))
            best = rc;
          if (best == pos)
            break;
          swap_entries(pos, best);
          pos = best;
        end
      end else begin
        r.status = mhpq_pkg::STAT_EMPTY;
      end
    end
    r.top_valid = (heap_fill > 0);
    r.top_prio = (heap_fill > 0) ? heap_mem[0].prio : 16'd0;
    r.top_tag = (heap_fill > 0) ? heap_mem[0].tag : 32'd0;
    r.count = heap_fill[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR: result %0d %s: got %0h expected %0h", result_index, what, got, want);
    error_count++;
  endtask

  task automatic send_request(logic rt, logic [15:0] pr, logic [31:0] pl);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pl, pr};
    s_axis_tuser <= rt;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(heap_update(rt, pr, pl));
    sent_count++;
  endtask

  task automatic check_result();
    heap_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", '0, '0);
    end else begin
      want = expected_results.pop_front();
      if (m_axis_tuser[1:0] !== want.status)
        report_mismatch("status", 32'(m_axis_tuser[1:0]), 32'(want.status));
      if (m_axis_tdata[15:0] !== want.rem_prio)
        report_mismatch("removed_priority", 32'(m_axis_tdata[15:0]), 32'(want.rem_prio));
      if (m_axis_tdata[47:16] !== want.rem_tag)
        report_mismatch("removed_payload", m_axis_tdata[47:16], want.rem_tag);
      if (m_axis_tuser[2] !== want.top_valid)
        report_mismatch("top_valid", 32'(m_axis_tuser[2]), 32'(want.top_valid));
      if (m_axis_tdata[63:48] !== want.top_prio)
        report_mismatch("top_priority", 32'(m_axis_tdata[63:48]), 32'(want.top_prio));
      if (m_axis_tdata[95:64] !== want.top_tag)
        report_mismatch("top_payload", m_axis_tdata[95:64], want.top_tag);
      if (m_axis_tdata[102:96] !== want.count)
        report_mismatch("entry_count", 32'(m_axis_tdata[102:96]), 32'(want.count));
    end
    result_index++;
  endtask

  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_cycles > 0) begin
        stall = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        stall = gap_free ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      check_result();
    end
  end

  function automatic logic [15:0] draw_priority(int mode);
    logic [15:0] p;
    case (mode)
      0: p = 16'($urandom);
      1: p = 16'($urandom_range(0, 6)) - 16'd3;
      default: begin
        case ($urandom_range(0, 3))
          0: p = 16'h8000;
          1: p = 16'h7fff;
          2: p = 16'h0000;
          default: p = 16'hffff;
        endcase
      end
    endcase
    return p;
  endfunction

  task automatic test_directed_cases();
    send_request(mhpq_pkg::REQ_DEQ, 16'($urandom), $urandom);
    send_request(mhpq_pkg::REQ_ENQ, 16'h7fff, 32'hffff_ffff);
    send_request(mhpq_pkg::REQ_ENQ, 16'h8000, 32'h0000_0000);
    send_request(mhpq_pkg::REQ_ENQ, 16'h0000, 32'h5555_5555);
    send_request(mhpq_pkg::REQ_ENQ, 16'hffff, 32'haaaa_aaaa);
    send_request(mhpq_pkg::REQ_ENQ, 16'd5, 32'd1);
    send_request(mhpq_pkg::REQ_ENQ, 16'd5, 32'd2);
    send_request(mhpq_pkg::REQ_ENQ, 16'd5, 32'd3);
    send_request(mhpq_pkg::REQ_ENQ, 16'h7fff, 32'h0000_1234);
    repeat (9) send_request(mhpq_pkg::REQ_DEQ, 16'($urandom), $urandom);
    send_request(mhpq_pkg::REQ_DEQ, 16'hffff, 32'hffff_ffff);
    send_request(mhpq_pkg::REQ_ENQ, 16'd1, 32'hdead_beef);
    send_request(mhpq_pkg::REQ_DEQ, 16'($urandom), $urandom);
  endtask

  task automatic test_fill_and_drain();
    gap_free = 1'b1;
    repeat (CAP) send_request(mhpq_pkg::REQ_ENQ, draw_priority(0), $urandom);
    send_request(mhpq_pkg::REQ_ENQ, 16'h7fff, $urandom);
    send_request(mhpq_pkg::REQ_ENQ, 16'h8000, $urandom);
    gap_free = 1'b0;
    repeat (CAP + 1) send_request(mhpq_pkg::REQ_DEQ, 16'($urandom), $urandom);
  endtask

  task automatic test_backpressure();
    long_hold_cycles = 300;
    gap_free = 1'b1;
    repeat (30) send_request(($urandom_range(0, 3) == 0) ? mhpq_pkg::REQ_DEQ
                                                         : mhpq_pkg::REQ_ENQ,
                             draw_priority(0), $urandom);
    gap_free = 1'b0;
  endtask

  task automatic test_random_mix();
    int enq_pct, prio_mode, phase_len, goal;
    logic rt;
    goal = sent_count + RANDOM_ITEMS;
    while (sent_count < goal) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      prio_mode = $urandom_range(0, 2);
      gap_free = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) begin
        if (sent_count < goal) begin
          rt = ($urandom_range(1, 100) <= enq_pct) ? mhpq_pkg::REQ_ENQ : mhpq_pkg::REQ_DEQ;
          send_request(rt, draw_priority(prio_mode), $urandom);
        end
      end
    end
    gap_free = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
